[hdl/akdr_pkg.sv]
// shared types and constants for the analog keypad debounce and repeat block
// register indexes, reset values and field widths; no dependencies
package akdr_pkg;

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int TICK_W   = 16;
    localparam int KEY_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TH_RIGHT  = 4'd0,
        REG_TH_UP     = 4'd1,
        REG_TH_DOWN   = 4'd2,
        REG_TH_LEFT   = 4'd3,
        REG_TH_SELECT = 4'd4,
        REG_VERIFY    = 4'd5,
        REG_HOLD      = 4'd6,
        REG_REPEAT    = 4'd7
    } t_reg_idx;

    // reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] TH_RIGHT_RST  = 10'd60;
    localparam logic [SAMPLE_W-1:0] TH_UP_RST     = 10'd200;
    localparam logic [SAMPLE_W-1:0] TH_DOWN_RST   = 10'd400;
    localparam logic [SAMPLE_W-1:0] TH_LEFT_RST   = 10'd600;
    localparam logic [SAMPLE_W-1:0] TH_SELECT_RST = 10'd800;
    localparam logic [TICK_W-1:0]   VERIFY_RST    = 16'd25;
    localparam logic [TICK_W-1:0]   HOLD_RST      = 16'd1000;
    localparam logic [TICK_W-1:0]   REPEAT_RST    = 16'd400;

    // internal key code: zero is no key, else output key code plus one
    localparam logic [KEY_W-1:0] KEY_NONE   = 3'd0;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 3'd1;
    localparam logic [KEY_W-1:0] KEY_UP     = 3'd2;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 3'd3;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 3'd4;
    localparam logic [KEY_W-1:0] KEY_SELECT = 3'd5;

    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

endpackage

[hdl/analog_keypad_debounce_repeat.sv]
// analog keypad debounce and auto-repeat, top level
// depends on akdr_pkg for register indexes, reset values and widths
//
// usage:
//   slave stream: one transaction per millisecond tick, tdata[9:0] holds the
//   converter sample of the key ladder. master stream: one transaction per
//   key event, tdata[2:0] is the key code (0 right, 1 up, 2 down, 3 left,
//   4 select), tuser[0] is 0 for the first press and 1 for held or repeat.
//   most ticks give no event.
//   config channel: index 0..7 selects the five ladder thresholds and the
//   verify, hold and repeat tick counts; other indexes are dropped. always
//   ready, write only while the block is idle.
// timing:
//   input register, then classify, timer and phase update combinationally into
//   the output register, which takes the event when its tick leaves the input
//   register; one tick per cycle while the master side does not stall.
// reset and stall:
//   reset restores the register defaults and releases the key. when the
//   master side stalls with an event pending, the input register still
//   takes one more tick, then the slave side stalls until the event leaves.
module analog_keypad_debounce_repeat (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: [9:0] adc_sample, [15:10] zero
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,
    // master stream: [2:0] key_code, [7:3] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,
    // tuser: [0] held_down
    output logic [0:0]  o_m_axis_tuser,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [akdr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [akdr_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_VERIFY   = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_HELD     = 2'd3
    } t_phase;

    // configuration registers
    logic [akdr_pkg::SAMPLE_W-1:0] r_th_right, r_th_up, r_th_down, r_th_left, r_th_select;
    logic [akdr_pkg::TICK_W-1:0]   r_verify, r_hold, r_repeat;

    // input stage
    logic                          r_in_valid;
    logic [akdr_pkg::SAMPLE_W-1:0] r_sample;

    // key state
    t_phase                        r_phase, n_phase;
    logic [akdr_pkg::KEY_W-1:0]    r_cur_key, n_cur_key;
    logic [akdr_pkg::TICK_W-1:0]   r_elapsed, n_elapsed;
    logic [akdr_pkg::TICK_W-1:0]   r_target, n_target;
    logic                          r_running, n_running;

    // output stage
    logic                          r_out_valid;
    logic [akdr_pkg::KEY_W-1:0]    r_out_key;
    logic                          r_out_held;

    logic                          w_out_free;
    logic                          w_step;
    logic [akdr_pkg::KEY_W-1:0]    w_key;
    logic [akdr_pkg::TICK_W-1:0]   w_el_inc;
    logic                          w_emit;
    logic                          w_emit_held;

    assign o_cfg_ready = 1'b1;

    // handshake between the stages
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_step;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_key};
    assign o_m_axis_tuser  = r_out_held;

    // ladder classification, first threshold that holds wins
    always_comb begin
        if (r_sample < r_th_right) begin
            w_key = akdr_pkg::KEY_RIGHT;
        end else if (r_sample < r_th_up) begin
            w_key = akdr_pkg::KEY_UP;
        end else if (r_sample < r_th_down) begin
            w_key = akdr_pkg::KEY_DOWN;
        end else if (r_sample < r_th_left) begin
            w_key = akdr_pkg::KEY_LEFT;
        end else if (r_sample < r_th_select) begin
            w_key = akdr_pkg::KEY_SELECT;
        end else begin
            w_key = akdr_pkg::KEY_NONE;
        end
    end

    // saturating tick count for this tick
    assign w_el_inc = (r_running && r_elapsed != akdr_pkg::TICK_MAX)
                    ? r_elapsed + 16'd1 : r_elapsed;

    // phase and timer update
    always_comb begin
        n_phase     = r_phase;
        n_cur_key   = r_cur_key;
        n_elapsed   = w_el_inc;
        n_target    = r_target;
        n_running   = r_running;
        w_emit      = 1'b0;
        w_emit_held = 1'b0;
        if (w_key == akdr_pkg::KEY_NONE) begin
            n_phase   = PH_RELEASED;
            n_cur_key = akdr_pkg::KEY_NONE;
            n_elapsed = '0;
            n_running = 1'b0;
        end else if (w_key != r_cur_key) begin
            // new key restarts the verify wait
            n_phase   = PH_VERIFY;
            n_cur_key = w_key;
            n_target  = r_verify;
            n_elapsed = '0;
            n_running = 1'b1;
        end else if (r_running && w_el_inc >= r_target) begin
            n_running = 1'b0;
            case (r_phase)
                PH_VERIFY: begin
                    w_emit    = 1'b1;
                    n_phase   = PH_PRESSED;
                    n_target  = r_hold;
                    n_elapsed = '0;
                    n_running = 1'b1;
                end
                PH_PRESSED, PH_HELD: begin
                    w_emit      = 1'b1;
                    w_emit_held = 1'b1;
                    n_phase     = PH_HELD;
                    n_target    = r_repeat;
                    n_elapsed   = '0;
                    n_running   = 1'b1;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th_right  <= akdr_pkg::TH_RIGHT_RST;
            r_th_up     <= akdr_pkg::TH_UP_RST;
            r_th_down   <= akdr_pkg::TH_DOWN_RST;
            r_th_left   <= akdr_pkg::TH_LEFT_RST;
            r_th_select <= akdr_pkg::TH_SELECT_RST;
            r_verify    <= akdr_pkg::VERIFY_RST;
            r_hold      <= akdr_pkg::HOLD_RST;
            r_repeat    <= akdr_pkg::REPEAT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                akdr_pkg::REG_TH_RIGHT:  r_th_right  <= i_cfg_data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_UP:     r_th_up     <= i_cfg_data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_DOWN:   r_th_down   <= i_cfg_data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_LEFT:   r_th_left   <= i_cfg_data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_SELECT: r_th_select <= i_cfg_data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_VERIFY:    r_verify    <= i_cfg_data;
                akdr_pkg::REG_HOLD:      r_hold      <= i_cfg_data;
                akdr_pkg::REG_REPEAT:    r_repeat    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_sample <= i_s_axis_tdata[akdr_pkg::SAMPLE_W-1:0];
        end
    end

    // key state, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RELEASED;
            r_cur_key <= akdr_pkg::KEY_NONE;
            r_elapsed <= '0;
            r_target  <= '0;
            r_running <= 1'b0;
        end else if (w_step) begin
            r_phase   <= n_phase;
            r_cur_key <= n_cur_key;
            r_elapsed <= n_elapsed;
            r_target  <= n_target;
            r_running <= n_running;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step && w_emit) begin
            r_out_key  <= r_cur_key - 3'd1;
            r_out_held <= w_emit_held;
        end
    end

endmodule

[sim/analog_keypad_debounce_repeat_tb.sv]
// self-checking testbench for the analog keypad debounce and auto-repeat block
// drives converter ticks and register writes, predicts key events in a scoreboard class
// depends on akdr_pkg and analog_keypad_debounce_repeat
module analog_keypad_debounce_repeat_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PHASES        = 12;
    localparam int  PHASE_TICKS   = 64;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  NO_KEY_BAND   = 5;
    localparam int  LONG_WAIT     = 40;
    localparam int  LONG_HOLD     = 130;
    localparam real TIMEOUT_NS    = 4_000_000.0;
    // index outside the register map, must be dropped
    localparam logic [akdr_pkg::CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 4'd12;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_VERIFY   = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_HELD     = 2'd3
    } t_key_phase;

    typedef struct packed {
        logic [akdr_pkg::KEY_W-1:0] key_code;
        logic                       held;
    } t_key_event;

    // keypad predictor and queue of key events still due
    class t_keypad_scoreboard;
        logic [akdr_pkg::SAMPLE_W-1:0] ladder_th[5];
        logic [akdr_pkg::TICK_W-1:0]   verify_len;
        logic [akdr_pkg::TICK_W-1:0]   hold_len;
        logic [akdr_pkg::TICK_W-1:0]   repeat_len;
        t_key_phase                    phase;
        logic [akdr_pkg::KEY_W-1:0]    cur_key;
        logic [akdr_pkg::TICK_W-1:0]   elapsed;
        logic [akdr_pkg::TICK_W-1:0]   target;
        bit                            running;
        t_key_event                    due_events[$];
        int                            errors;
        int                            events_seen;

        function new();
            ladder_th  = '{akdr_pkg::TH_RIGHT_RST, akdr_pkg::TH_UP_RST,
                           akdr_pkg::TH_DOWN_RST, akdr_pkg::TH_LEFT_RST,
                           akdr_pkg::TH_SELECT_RST};
            verify_len = akdr_pkg::VERIFY_RST;
            hold_len   = akdr_pkg::HOLD_RST;
            repeat_len = akdr_pkg::REPEAT_RST;
            phase      = PH_RELEASED;
            cur_key    = akdr_pkg::KEY_NONE;
            elapsed    = '0;
            target     = '0;
            running    = 1'b0;
            errors     = 0;
            events_seen = 0;
        endfunction

        function int pending();
            return due_events.size();
        endfunction

        function void write_reg(logic [akdr_pkg::CFG_IDX_W-1:0] idx,
                                logic [akdr_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                akdr_pkg::REG_TH_RIGHT:  ladder_th[0] = data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_UP:     ladder_th[1] = data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_DOWN:   ladder_th[2] = data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_LEFT:   ladder_th[3] = data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_TH_SELECT: ladder_th[4] = data[akdr_pkg::SAMPLE_W-1:0];
                akdr_pkg::REG_VERIFY:    verify_len   = data[akdr_pkg::TICK_W-1:0];
                akdr_pkg::REG_HOLD:      hold_len     = data[akdr_pkg::TICK_W-1:0];
                akdr_pkg::REG_REPEAT:    repeat_len   = data[akdr_pkg::TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void arm_timer(logic [akdr_pkg::TICK_W-1:0] len);
            target  = len;
            elapsed = '0;
            running = 1'b1;
        endfunction

        // one accepted tick: advance the timer, classify, update the phase
        function void note_tick(logic [akdr_pkg::SAMPLE_W-1:0] sample);
            logic [akdr_pkg::KEY_W-1:0] key;
            t_key_event                 ev;
            int                         k;
            if (running && elapsed != akdr_pkg::TICK_MAX) begin
                elapsed = elapsed + 1'b1;
            end
            // lowest matching threshold wins, so scan from the top down
            key = akdr_pkg::KEY_NONE;
            for (k = 4; k >= 0; k--) begin
                if (sample < ladder_th[k]) key = akdr_pkg::KEY_W'(k + 1);
            end
            if (key == akdr_pkg::KEY_NONE) begin
                phase   = PH_RELEASED;
                cur_key = akdr_pkg::KEY_NONE;
                elapsed = '0;
                running = 1'b0;
            end else if (key != cur_key) begin
                phase   = PH_VERIFY;
                cur_key = key;
                arm_timer(verify_len);
            end else if (running && elapsed >= target) begin
                // one-shot timer ran out
                running = 1'b0;
                if (phase != PH_RELEASED) begin
                    ev.key_code = key - 1'b1;
                    ev.held     = (phase != PH_VERIFY);
                    due_events.push_back(ev);
                    if (phase == PH_VERIFY) begin
                        phase = PH_PRESSED;
                        arm_timer(hold_len);
                    end else begin
                        phase = PH_HELD;
                        arm_timer(repeat_len);
                    end
                end
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_event(logic [7:0] tdata, logic [0:0] tuser);
            t_key_event want;
            if (due_events.size() == 0) begin
                report_mismatch($sformatf("key event with none due: tdata %0h tuser %0b",
                                          tdata, tuser));
            end else begin
                want = due_events.pop_front();
                events_seen++;
                if (tdata !== {{(8-akdr_pkg::KEY_W){1'b0}}, want.key_code})
                    report_mismatch($sformatf("key_code got tdata %0h want %0d",
                                              tdata, want.key_code));
                if (tuser[0] !== want.held)
                    report_mismatch($sformatf("held_down got %0b want %0b on key %0d",
                                              tuser[0], want.held, want.key_code));
            end
        endtask
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [15:0]                    i_s_axis_tdata = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [7:0]                     o_m_axis_tdata;
    logic [0:0]                     o_m_axis_tuser;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [akdr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [akdr_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    t_keypad_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int ticks_sent     = 0;
    int writes_done    = 0;

    analog_keypad_debounce_repeat uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // event monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_event(o_m_axis_tdata, o_m_axis_tuser);
    end

    // one tick transaction, with random sender gaps ahead of it
    task automatic send_tick(logic [akdr_pkg::SAMPLE_W-1:0] sample);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(16-akdr_pkg::SAMPLE_W){1'b0}}, sample};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_tick(sample);
        ticks_sent++;
    endtask

    // register write transaction, valid is left for the next driver to lower
    task automatic cfg_write(logic [akdr_pkg::CFG_IDX_W-1:0] idx,
                             logic [akdr_pkg::CFG_DAT_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b1;
        i_cfg_index     <= idx;
        i_cfg_data      <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        writes_done++;
    endtask

    // hold off until every due event has left and the pipeline is quiet
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sample inside the band of key k under the current thresholds, or no key
    function automatic logic [akdr_pkg::SAMPLE_W-1:0] band_sample(int k);
        int lo;
        int hi;
        int j;
        lo = 0;
        for (j = 0; j < k; j++) begin
            if (int'(sb.ladder_th[j]) > lo) lo = int'(sb.ladder_th[j]);
        end
        hi = (k < NO_KEY_BAND) ? int'(sb.ladder_th[k]) - 1 : 1023;
        if (hi < lo) return akdr_pkg::SAMPLE_W'($urandom_range(1023));
        return akdr_pkg::SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    initial begin
        int                            directed_samples[$];
        logic [akdr_pkg::SAMPLE_W-1:0] th[5];
        logic [akdr_pkg::SAMPLE_W-1:0] swap;
        logic [akdr_pkg::SAMPLE_W-1:0] long_sample;
        int                            i;
        int                            j;
        int                            ph;
        int                            phase_end;
        int                            r;
        int                            k;
        int                            len;

        directed_samples = '{0, 0, 0, 0, 59, 60, 199, 200, 399, 400, 599, 600,
                             799, 800, 1023, 512, 512, 1023};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default ladder, zero waits so every tick can give an event
        cfg_write(akdr_pkg::REG_VERIFY, '0);
        cfg_write(akdr_pkg::REG_HOLD, '0);
        cfg_write(akdr_pkg::REG_REPEAT, '0);
        for (i = 0; i < directed_samples.size(); i++) begin
            // sender waits for the right-key repeats to leave before moving on
            if (i == 5) drain();
            send_tick(akdr_pkg::SAMPLE_W'(directed_samples[i]));
        end

        // longer waits: press, held and repeat events on a steady select key
        drain();
        cfg_write(akdr_pkg::REG_VERIFY, akdr_pkg::CFG_DAT_W'(LONG_WAIT));
        cfg_write(akdr_pkg::REG_HOLD, akdr_pkg::CFG_DAT_W'(LONG_WAIT));
        cfg_write(akdr_pkg::REG_REPEAT, akdr_pkg::CFG_DAT_W'(LONG_WAIT));
        for (i = 0; i < LONG_HOLD; i++) begin
            long_sample = band_sample(4);
            send_tick(long_sample);
        end
        send_tick(band_sample(NO_KEY_BAND));

        // random phases, each with its own ladder, timing and idling
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            case (ph % 6)
                0, 1: begin
                    for (i = 0; i < 5; i++)
                        th[i] = akdr_pkg::SAMPLE_W'($urandom_range(1023));
                end
                2: th = '{10'd0, 10'd256, 10'd512, 10'd768, 10'd1023};
                3: th = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023};
                4: th = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
                default: th = '{akdr_pkg::TH_RIGHT_RST, akdr_pkg::TH_UP_RST,
                                akdr_pkg::TH_DOWN_RST, akdr_pkg::TH_LEFT_RST,
                                akdr_pkg::TH_SELECT_RST};
            endcase
            // ascending ladder for the first kind, out of order for the second
            if (ph % 6 == 0) begin
                for (i = 0; i < 4; i++) begin
                    for (j = 0; j < 4 - i; j++) begin
                        if (th[j] > th[j+1]) begin
                            swap    = th[j];
                            th[j]   = th[j+1];
                            th[j+1] = swap;
                        end
                    end
                end
            end
            // upper data bits of threshold writes carry junk
            for (i = 0; i < 5; i++)
                cfg_write(akdr_pkg::t_reg_idx'(akdr_pkg::REG_TH_RIGHT + i),
                          {6'($urandom_range(63)), th[i]});
            cfg_write(akdr_pkg::REG_VERIFY, akdr_pkg::TICK_W'($urandom_range(6)));
            cfg_write(akdr_pkg::REG_HOLD, akdr_pkg::TICK_W'($urandom_range(25)));
            cfg_write(akdr_pkg::REG_REPEAT, akdr_pkg::TICK_W'($urandom_range(8)));
            if ($urandom_range(3) == 0)
                cfg_write(CFG_IDX_UNMAPPED, akdr_pkg::CFG_DAT_W'($urandom));

            phase_end = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end) begin
                r = $urandom_range(99);
                if (r < 80) begin
                    // key press with the odd glitch, then release or a direct key change
                    k   = $urandom_range(4);
                    len = $urandom_range(40, 1);
                    for (i = 0; i < len; i++) begin
                        if ($urandom_range(19) == 0)
                            send_tick(akdr_pkg::SAMPLE_W'($urandom_range(1023)));
                        else
                            send_tick(band_sample(k));
                    end
                    len = $urandom_range(4);
                    for (i = 0; i < len; i++) send_tick(band_sample(NO_KEY_BAND));
                end else if (r < 97) begin
                    // raw noise
                    len = $urandom_range(5, 1);
                    for (i = 0; i < len; i++)
                        send_tick(akdr_pkg::SAMPLE_W'($urandom_range(1023)));
                end else begin
                    drain();
                end
            end
        end

        drain();
        $display("covered %0d ticks, %0d key events, %0d register writes over %0d phases",
                 ticks_sent, sb.events_seen, writes_done, PHASES);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
